// ----- hw/rtl/gtac_pkg.sv -----
// Shared types, constants and helpers for the glucose trend arrow classifier.
`timescale 1ns / 1ps
package gtac_pkg;

    localparam int GLUCOSE_W = 13;
    localparam int LEVEL_W   = 14;
    localparam int BAND_W    = 10;
    localparam int LOWLVL_W  = 13;
    localparam int TREND_W   = 4;
    localparam int RUN_W     = 8;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    // register indexes
    localparam logic [1:0] REG_FLAT_BAND = 2'd0;
    localparam logic [1:0] REG_STEP_BAND = 2'd1;
    localparam logic [1:0] REG_MID_BAND  = 2'd2;
    localparam logic [1:0] REG_LOW_LEVEL = 2'd3;

    localparam logic [BAND_W-1:0]   FLAT_BAND_RST = 10'd30;
    localparam logic [BAND_W-1:0]   STEP_BAND_RST = 10'd10;
    localparam logic [BAND_W-1:0]   MID_BAND_RST  = 10'd55;
    localparam logic [LOWLVL_W-1:0] LOW_LEVEL_RST = 13'd450;

    // trend codes
    localparam logic signed [TREND_W-1:0] TREND_FAST_FALL = -4'sd2;
    localparam logic signed [TREND_W-1:0] TREND_FALL      = -4'sd1;
    localparam logic signed [TREND_W-1:0] TREND_STEADY    = 4'sd0;
    localparam logic signed [TREND_W-1:0] TREND_RISE      = 4'sd1;
    localparam logic signed [TREND_W-1:0] TREND_FAST_RISE = 4'sd2;
    localparam logic signed [TREND_W-1:0] TREND_FIRST     = 4'sd5;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

    // reciprocal of 10 in 2^-19 units, exact for dividends below 43698
    localparam int          RECIP_SHIFT = 19;
    localparam logic [15:0] RECIP_TEN   = 16'd52429;

    typedef struct packed {
        logic [BAND_W-1:0]   flat_band;
        logic [BAND_W-1:0]   step_band;
        logic [BAND_W-1:0]   mid_band;
        logic [LOWLVL_W-1:0] low_level;
    } gtac_cfg_t;

    function automatic logic [RUN_W-1:0] run_bump(input logic [RUN_W-1:0] c);
        return (c == RUN_MAX) ? RUN_MAX : c + RUN_W'(1);
    endfunction

endpackage

// ----- hw/rtl/gtac_round.sv -----
// Rounds a reading half-up to tenths, result kept in hundredths.
`timescale 1ns / 1ps
module gtac_round (
    input  logic [gtac_pkg::GLUCOSE_W-1:0] glucose_hundredths,
    output logic [gtac_pkg::LEVEL_W-1:0]   level
);
    import gtac_pkg::*;

    logic [LEVEL_W-1:0] biased;
    logic [29:0]        prod;
    logic [9:0]         tenths;

    always_comb
    begin
        biased = LEVEL_W'(glucose_hundredths) + LEVEL_W'(5);
        prod   = 30'(biased) * 30'(RECIP_TEN);
        tenths = prod[RECIP_SHIFT +: 10];
        // times ten as shift-add
        level  = LEVEL_W'({tenths, 3'b000}) + LEVEL_W'({tenths, 1'b0});
    end

endmodule

// ----- hw/rtl/gtac_regs.sv -----
// APB configuration registers for the trend classifier.
`timescale 1ns / 1ps
module gtac_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gtac_pkg::ADDR_W-1:0]   paddr,
    input  logic [gtac_pkg::DATA_W-1:0]   pwdata,
    output logic [gtac_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output gtac_pkg::gtac_cfg_t           cfg
);
    import gtac_pkg::*;

    gtac_cfg_t  cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flat_band <= FLAT_BAND_RST;
            cfg_reg.step_band <= STEP_BAND_RST;
            cfg_reg.mid_band  <= MID_BAND_RST;
            cfg_reg.low_level <= LOW_LEVEL_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FLAT_BAND: cfg_reg.flat_band <= pwdata[BAND_W-1:0];
                REG_STEP_BAND: cfg_reg.step_band <= pwdata[BAND_W-1:0];
                REG_MID_BAND:  cfg_reg.mid_band  <= pwdata[BAND_W-1:0];
                REG_LOW_LEVEL: cfg_reg.low_level <= pwdata[LOWLVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FLAT_BAND: prdata = DATA_W'(cfg_reg.flat_band);
            REG_STEP_BAND: prdata = DATA_W'(cfg_reg.step_band);
            REG_MID_BAND:  prdata = DATA_W'(cfg_reg.mid_band);
            REG_LOW_LEVEL: prdata = DATA_W'(cfg_reg.low_level);
            default:       prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/gtac_core.sv -----
// Trend classification, run counters and per-session trend state.
`timescale 1ns / 1ps
module gtac_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gtac_pkg::gtac_cfg_t                 cfg,
    input  logic                                advance,
    input  logic [gtac_pkg::LEVEL_W-1:0]        level,
    input  logic                                first_reading,
    output logic signed [gtac_pkg::TREND_W-1:0] trend_code
);
    import gtac_pkg::*;

    logic [LEVEL_W-1:0]         last_level_reg;
    logic signed [TREND_W-1:0]  last_trend_reg;
    logic [RUN_W-1:0]           fall_run_reg, rise_run_reg, steady_run_reg, hold_run_reg;
    logic [RUN_W-1:0]           fall_run_next, rise_run_next, steady_run_next, hold_run_next;

    logic signed [LEVEL_W:0]    diff;
    logic signed [LEVEL_W:0]    diff_neg;
    logic signed [LEVEL_W:0]    step_pos;
    logic signed [LEVEL_W:0]    step_neg;
    logic [LEVEL_W-1:0]         adiff;
    logic                       neg;
    logic signed [TREND_W-1:0]  sgn, sgn2;
    logic signed [TREND_W-1:0]  t_base, t_pull, t_steady, t_hold;

    always_comb
    begin
        diff     = $signed({1'b0, level}) - $signed({1'b0, last_level_reg});
        neg      = diff[LEVEL_W];
        diff_neg = -diff;
        adiff    = neg ? diff_neg[LEVEL_W-1:0] : diff[LEVEL_W-1:0];
        sgn      = neg ? TREND_FALL : TREND_RISE;
        sgn2     = neg ? TREND_FAST_FALL : TREND_FAST_RISE;
        step_pos = $signed({{(LEVEL_W+1-BAND_W){1'b0}}, cfg.step_band});
        step_neg = -step_pos;

        if (adiff < LEVEL_W'(cfg.flat_band))
        begin
            if (level < LEVEL_W'(cfg.low_level))
                t_base = (adiff < LEVEL_W'(cfg.step_band)) ? TREND_STEADY : sgn;
            else
                t_base = TREND_STEADY;
        end
        else if (adiff < LEVEL_W'(cfg.mid_band))
            t_base = sgn;
        else if (last_trend_reg == sgn || last_trend_reg == sgn2)
            t_base = sgn2;
        else
            t_base = sgn;

        fall_run_next   = (diff < step_neg) ? run_bump(fall_run_reg) : '0;
        rise_run_next   = (diff > step_pos) ? run_bump(rise_run_reg) : '0;
        steady_run_next = (t_base == TREND_STEADY) ? run_bump(steady_run_reg) : '0;

        t_pull = t_base;
        if (rise_run_next >= RUN_W'(2) && t_pull == TREND_STEADY)
            t_pull = TREND_RISE;
        if (fall_run_next >= RUN_W'(2) && t_pull == TREND_STEADY)
            t_pull = TREND_FALL;

        // strong arrow pulled back after a steady stretch
        t_steady = t_pull;
        if (steady_run_next >= RUN_W'(2))
        begin
            if (last_trend_reg > TREND_RISE)
                t_steady = TREND_RISE;
            if (last_trend_reg < TREND_FALL)
                t_steady = TREND_FALL;
        end

        t_hold = t_steady;
        if (last_trend_reg == t_steady)
            hold_run_next = run_bump(hold_run_reg);
        else
        begin
            if (hold_run_reg > RUN_W'(2))
                t_hold = last_trend_reg;
            hold_run_next = '0;
        end

        trend_code = first_reading ? TREND_FIRST : t_hold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= '0;
            last_trend_reg <= TREND_STEADY;
            fall_run_reg   <= '0;
            rise_run_reg   <= '0;
            steady_run_reg <= '0;
            hold_run_reg   <= '0;
        end
        else if (advance)
        begin
            last_level_reg <= level;
            last_trend_reg <= trend_code;
            fall_run_reg   <= fall_run_next;
            rise_run_reg   <= rise_run_next;
            steady_run_reg <= steady_run_next;
            hold_run_reg   <= hold_run_next;
        end
    end

    // a difference cannot be both beyond +step and below -step
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rise_run_reg != '0 && fall_run_reg != '0))
        else $error("rise and fall runs active together");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && first_reading |=> last_trend_reg == TREND_FIRST)
        else $error("first reading did not store code 5");

    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(last_level_reg) && $stable(hold_run_reg))
        else $error("trend state changed without an item");

endmodule

// ----- hw/rtl/glucose_trend_arrow_classifier_unit.sv -----
// Glucose trend arrow classifier: top level with stream ports and APB registers.
// Pipeline: an accepted item passes through the input register, then the output
// register that drives m_tvalid; m_tready low holds items in both.
// Throughput: one item per cycle while m_tready stays high; the trend state updates
// as an item leaves the input register.
// Reset (rst_n low, asynchronous) clears the pipeline, the trend state and
// restores the register defaults.
`timescale 1ns / 1ps
module glucose_trend_arrow_classifier_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [12:0] glucose_hundredths
    input  logic                          s_tuser,   // [0] first_reading
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [3:0] trend_code
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gtac_pkg::ADDR_W-1:0]   paddr,
    input  logic [gtac_pkg::DATA_W-1:0]   pwdata,
    output logic [gtac_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import gtac_pkg::*;

    gtac_cfg_t                 cfg;
    logic [LEVEL_W-1:0]        in_level;
    logic                      a_valid_reg;
    logic [LEVEL_W-1:0]        a_level_reg;
    logic                      a_first_reg;
    logic                      out_valid_reg;
    logic signed [TREND_W-1:0] out_code_reg;
    logic signed [TREND_W-1:0] trend_code;
    logic                      advance;

    gtac_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gtac_round u_round (
        .glucose_hundredths (s_tdata[GLUCOSE_W-1:0]),
        .level              (in_level)
    );

    gtac_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .advance       (advance),
        .level         (a_level_reg),
        .first_reading (a_first_reg),
        .trend_code    (trend_code)
    );

    assign advance  = a_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_code_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                a_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            a_level_reg <= in_level;
            a_first_reg <= s_tuser;
        end
        if (advance)
            out_code_reg <= trend_code;
    end

endmodule
